// ===== hdl/cfhp_pkg.sv =====
// Shared types, constants and the tag length table of the class file parser.
`timescale 1ns / 1ps

package cfhp_pkg;

  localparam int unsigned OUT_OFFSET_W = 24;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [31:0] CLASS_MAGIC = 32'hCAFEBABE;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_MINOR,
    PH_MAJOR,
    PH_POOLCNT,
    PH_TAG,
    PH_UTFLEN,
    PH_SKIP,
    PH_ACCESS,
    PH_THIS,
    PH_SUPER,
    PH_IFCNT,
    PH_IFACE,
    PH_DONE,
    PH_ERROR
  } phase_t;

  localparam logic [2:0] KIND_POOL = 3'd0;
  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_IFACE = 3'd2;
  localparam logic [2:0] KIND_FINISHED = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ERR_BAD_TAG = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  localparam logic [3:0] BODY_INVALID = 4'd0;
  localparam logic [3:0] BODY_UTF8 = 4'd15;
  localparam logic [15:0] WIDE_BODY = 16'd8;

  localparam logic [7:0] TAG_LONG = 8'd5;
  localparam logic [7:0] TAG_DOUBLE = 8'd6;

  // Second word of a job: nothing, the finished word, or a truncation error.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_FINISH,
    TAIL_TRUNC
  } tail_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [15:0] slot;
    logic [OUT_OFFSET_W-1:0] offset;
    logic [7:0] tag;
    logic [15:0] minor;
    logic [15:0] major;
    logic [15:0] access;
    logic [15:0] this_idx;
    logic [15:0] super_idx;
    logic [15:0] iface;
    logic [1:0] err;
  } rec_t;

  typedef struct packed {
    logic head_valid;
    rec_t head;
    tail_t tail;
    logic [OUT_OFFSET_W-1:0] trunc_offset;
  } job_t;

  // Body length after the tag byte; BODY_UTF8 means a length word follows.
  function automatic logic [3:0] body_len(input logic [7:0] t);
    logic [3:0] len;
    case (t) inside
      8'd1: len = BODY_UTF8;
      8'd7, 8'd8, 8'd16, 8'd19, 8'd20: len = 4'd2;
      8'd15: len = 4'd3;
      8'd3, 8'd4, [8'd9:8'd12], 8'd17, 8'd18: len = 4'd4;
      8'd5, 8'd6: len = 4'd8;
      default: len = BODY_INVALID;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/cfhp_byte_if.sv =====
// Handshake channel that carries class file bytes.
`timescale 1ns / 1ps

interface cfhp_byte_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/cfhp_rec_if.sv =====
// Handshake channel that carries parse result words.
`timescale 1ns / 1ps

interface cfhp_rec_if;
  logic valid;
  logic ready;
  logic [2:0] record_kind;
  logic [15:0] slot_index;
  logic [23:0] entry_offset;
  logic [7:0] entry_tag;
  logic [15:0] minor_version;
  logic [15:0] major_version;
  logic [15:0] access_flags;
  logic [15:0] this_class_index;
  logic [15:0] super_class_index;
  logic [15:0] interface_index;
  logic [1:0] error_code;
  logic last_of_run;

  modport source(
    output valid, output record_kind, output slot_index, output entry_offset,
    output entry_tag, output minor_version, output major_version,
    output access_flags, output this_class_index, output super_class_index,
    output interface_index, output error_code, output last_of_run,
    input ready
  );
  modport sink(
    input valid, input record_kind, input slot_index, input entry_offset,
    input entry_tag, input minor_version, input major_version,
    input access_flags, input this_class_index, input super_class_index,
    input interface_index, input error_code, input last_of_run,
    output ready
  );
endinterface

// ===== hdl/class_file_header_parser.sv =====
// Top level of the class file header and constant pool parser.
//
// The stream channel takes one class file byte per word, with last_byte set
// on the final byte of a file. The results channel gives pool entry, class
// header, interface, finished and error words, with last_of_run set on the
// final word caused by one input byte.
// A byte is taken in every cycle while the job queue has room. The first
// word caused by a byte is written to the job queue, then offered from the
// output register once that register is free.
// A byte that causes two words (an interface index that ends the list, or a
// final byte that ends a file early) loads the output register twice, so
// the sender drains at one word per cycle while the receiver is ready.
// When the receiver stalls, words wait in the output register and the
// four-entry job queue; once the queue fills, ready drops on the stream.
// Reset clears the parse state, the queue and the output register; the
// parser then expects the magic word of a new file. The byte offset
// counter is OFFSET_BITS wide and wraps; the low 24 bits are reported.
`timescale 1ns / 1ps

module class_file_header_parser #(
  parameter int unsigned OFFSET_BITS = 24
) (
  input logic clk,
  input logic rst,
  cfhp_byte_if.sink stream,
  cfhp_rec_if.source results
);
  import cfhp_pkg::*;

  logic push;
  job_t push_job;
  logic pop;
  job_t head;
  logic empty;
  logic full;

  cfhp_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .stream(stream),
    .queue_full(full),
    .push(push),
    .job(push_job)
  );

  cfhp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .pop(pop),
    .head(head),
    .empty(empty),
    .full(full)
  );

  cfhp_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .empty(empty),
    .pop(pop),
    .results(results)
  );

endmodule

// ===== hdl/cfhp_front.sv =====
// Byte parser: walks the class file structure and builds result jobs.
`timescale 1ns / 1ps

module cfhp_front #(
  parameter int unsigned OFFSET_BITS = 24
) (
  input logic clk,
  input logic rst,
  cfhp_byte_if.sink stream,
  input logic queue_full,
  output logic push,
  output cfhp_pkg::job_t job
);
  import cfhp_pkg::*;

  phase_t phase;
  phase_t phase_next;
  phase_t phase_after;
  logic [1:0] field_count;
  logic [23:0] field_shift;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [16:0] pool_slot;
  logic [15:0] pool_count;
  logic [15:0] skip_remaining;
  logic cur_wide;
  logic [15:0] iface_pos;
  logic [15:0] iface_total;
  logic [15:0] minor;
  logic [15:0] major;
  logic [15:0] access;
  logic [15:0] this_idx;

  logic accept;
  logic [2:0] count_inc;
  logic [2:0] need;
  logic field_phase;
  logic field_done;
  logic [31:0] word32;
  logic [15:0] word16;
  logic [3:0] blen;
  logic [16:0] slot_adv;
  phase_t finish_phase;
  logic [15:0] skip_dec;
  logic [15:0] iface_inc;
  logic [OFFSET_BITS-1:0] offset_inc;
  logic [31:0] here_w;
  logic [31:0] next_w;
  logic trunc;

  assign accept = stream.valid && stream.ready;
  assign stream.ready = !queue_full;

  assign count_inc = {1'b0, field_count} + 3'd1;
  assign need = (phase == PH_MAGIC) ? 3'd4 : 3'd2;
  assign field_done = field_phase && (count_inc == need);
  assign word32 = {field_shift, stream.data_byte};
  assign word16 = {field_shift[7:0], stream.data_byte};
  assign blen = body_len(stream.data_byte);
  assign slot_adv = pool_slot + (cur_wide ? 17'd2 : 17'd1);
  assign finish_phase = (slot_adv >= {1'b0, pool_count}) ? PH_ACCESS : PH_TAG;
  assign skip_dec = skip_remaining - 16'd1;
  assign iface_inc = iface_pos + 16'd1;
  assign offset_inc = byte_offset + OFFSET_BITS'(1);
  assign here_w = 32'(byte_offset);
  assign next_w = 32'(offset_inc);

  always_comb begin
    case (phase)
      PH_MAGIC, PH_MINOR, PH_MAJOR, PH_POOLCNT, PH_UTFLEN, PH_ACCESS, PH_THIS,
      PH_SUPER, PH_IFCNT, PH_IFACE: field_phase = 1'b1;
      default: field_phase = 1'b0;
    endcase
  end

  always_comb begin
    phase_after = phase;
    case (phase)
      PH_MAGIC: if (field_done) begin
        phase_after = (word32 == CLASS_MAGIC) ? PH_MINOR : PH_ERROR;
      end
      PH_MINOR: if (field_done) begin
        phase_after = PH_MAJOR;
      end
      PH_MAJOR: if (field_done) begin
        phase_after = PH_POOLCNT;
      end
      PH_POOLCNT: if (field_done) begin
        phase_after = (word16 <= 16'd1) ? PH_ACCESS : PH_TAG;
      end
      PH_TAG: begin
        if (blen == BODY_INVALID) begin
          phase_after = PH_ERROR;
        end else if (blen == BODY_UTF8) begin
          phase_after = PH_UTFLEN;
        end else begin
          phase_after = PH_SKIP;
        end
      end
      PH_UTFLEN: if (field_done) begin
        phase_after = (word16 == 16'd0) ? finish_phase : PH_SKIP;
      end
      PH_SKIP: if (skip_dec == 16'd0) begin
        phase_after = finish_phase;
      end
      PH_ACCESS: if (field_done) begin
        phase_after = PH_THIS;
      end
      PH_THIS: if (field_done) begin
        phase_after = PH_SUPER;
      end
      PH_SUPER: if (field_done) begin
        phase_after = PH_IFCNT;
      end
      PH_IFCNT: if (field_done) begin
        phase_after = (word16 == 16'd0) ? PH_DONE : PH_IFACE;
      end
      PH_IFACE: if (field_done && (iface_inc >= iface_total)) begin
        phase_after = PH_DONE;
      end
      default: phase_after = phase;
    endcase
    trunc = stream.last_byte && (phase_after != PH_DONE) && (phase_after != PH_ERROR);
    phase_next = stream.last_byte ? PH_MAGIC : phase_after;
  end

  always_comb begin
    job = '0;
    job.tail = TAIL_NONE;
    case (phase)
      PH_MAGIC: if (field_done && (word32 != CLASS_MAGIC)) begin
        job.head_valid = 1'b1;
        job.head.kind = KIND_ERROR;
        job.head.err = ERR_BAD_MAGIC;
      end
      PH_TAG: begin
        job.head_valid = 1'b1;
        job.head.offset = here_w[OUT_OFFSET_W-1:0];
        job.head.tag = stream.data_byte;
        if (blen == BODY_INVALID) begin
          job.head.kind = KIND_ERROR;
          job.head.err = ERR_BAD_TAG;
        end else begin
          job.head.kind = KIND_POOL;
          job.head.slot = pool_slot[15:0];
        end
      end
      PH_SKIP: if (cur_wide && (skip_remaining == WIDE_BODY)) begin
        job.head_valid = 1'b1;
        job.head.kind = KIND_POOL;
        job.head.slot = 16'(pool_slot + 17'd1);
      end
      PH_SUPER: if (field_done) begin
        job.head_valid = 1'b1;
        job.head.kind = KIND_HEADER;
        job.head.minor = minor;
        job.head.major = major;
        job.head.access = access;
        job.head.this_idx = this_idx;
        job.head.super_idx = word16;
      end
      PH_IFCNT: if (field_done && (word16 == 16'd0)) begin
        job.tail = TAIL_FINISH;
      end
      PH_IFACE: if (field_done) begin
        job.head_valid = 1'b1;
        job.head.kind = KIND_IFACE;
        job.head.slot = iface_pos;
        job.head.iface = word16;
        if (iface_inc >= iface_total) begin
          job.tail = TAIL_FINISH;
        end
      end
      default: job.head_valid = 1'b0;
    endcase
    if (trunc) begin
      job.tail = TAIL_TRUNC;
      job.trunc_offset = next_w[OUT_OFFSET_W-1:0];
    end
  end

  assign push = accept && (job.head_valid || (job.tail != TAIL_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MAGIC;
      field_count <= '0;
      field_shift <= '0;
      byte_offset <= '0;
      pool_slot <= 17'd1;
    end else if (accept) begin
      phase <= phase_next;
      if (stream.last_byte) begin
        field_count <= '0;
        field_shift <= '0;
        byte_offset <= '0;
        pool_slot <= 17'd1;
      end else begin
        byte_offset <= offset_inc;
        if (field_phase) begin
          field_count <= field_done ? 2'd0 : count_inc[1:0];
          field_shift <= field_done ? 24'd0 : word32[23:0];
        end
        if ((phase == PH_POOLCNT) && field_done) begin
          pool_slot <= 17'd1;
        end
        if (((phase == PH_UTFLEN) && field_done && (word16 == 16'd0)) ||
            ((phase == PH_SKIP) && (skip_dec == 16'd0))) begin
          pool_slot <= slot_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (phase)
        PH_MINOR: if (field_done) begin
          minor <= word16;
        end
        PH_MAJOR: if (field_done) begin
          major <= word16;
        end
        PH_POOLCNT: if (field_done) begin
          pool_count <= word16;
        end
        PH_TAG: begin
          cur_wide <= (stream.data_byte == TAG_LONG) || (stream.data_byte == TAG_DOUBLE);
          skip_remaining <= 16'(blen);
        end
        PH_UTFLEN: if (field_done) begin
          skip_remaining <= word16;
        end
        PH_SKIP: skip_remaining <= skip_dec;
        PH_ACCESS: if (field_done) begin
          access <= word16;
        end
        PH_THIS: if (field_done) begin
          this_idx <= word16;
        end
        PH_IFCNT: if (field_done) begin
          iface_total <= word16;
          iface_pos <= 16'd0;
        end
        PH_IFACE: if (field_done) begin
          iface_pos <= iface_inc;
        end
        default: cur_wide <= cur_wide;
      endcase
    end
  end

endmodule

// ===== hdl/cfhp_queue.sv =====
// Short job queue between the byte parser and the result sender.
`timescale 1ns / 1ps

module cfhp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input logic clk,
  input logic rst,
  input logic push,
  input cfhp_pkg::job_t push_job,
  input logic pop,
  output cfhp_pkg::job_t head,
  output logic empty,
  output logic full
);
  import cfhp_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t slots [DEPTH];
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign empty = (count == '0);
  assign full = (count == CW'(DEPTH));
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== hdl/cfhp_back.sv =====
// Result sender: splits each job into words and holds them in an output register.
`timescale 1ns / 1ps

module cfhp_back (
  input logic clk,
  input logic rst,
  input cfhp_pkg::job_t head,
  input logic empty,
  output logic pop,
  cfhp_rec_if.source results
);
  import cfhp_pkg::*;

  logic second;
  logic out_valid;
  rec_t out_rec;
  logic out_last;
  rec_t pick;
  logic pick_last;
  logic load;

  always_comb begin
    pick = '0;
    if (!second && head.head_valid) begin
      pick = head.head;
      pick_last = (head.tail == TAIL_NONE);
    end else begin
      pick_last = 1'b1;
      if (head.tail == TAIL_TRUNC) begin
        pick.kind = KIND_ERROR;
        pick.offset = head.trunc_offset;
        pick.err = ERR_TRUNCATED;
      end else begin
        pick.kind = KIND_FINISHED;
      end
    end
  end

  assign load = !empty && (!out_valid || results.ready);
  assign pop = load && pick_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second <= !pick_last;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec <= pick;
      out_last <= pick_last;
    end
  end

  assign results.valid = out_valid;
  assign results.record_kind = out_rec.kind;
  assign results.slot_index = out_rec.slot;
  assign results.entry_offset = out_rec.offset;
  assign results.entry_tag = out_rec.tag;
  assign results.minor_version = out_rec.minor;
  assign results.major_version = out_rec.major;
  assign results.access_flags = out_rec.access;
  assign results.this_class_index = out_rec.this_idx;
  assign results.super_class_index = out_rec.super_idx;
  assign results.interface_index = out_rec.iface;
  assign results.error_code = out_rec.err;
  assign results.last_of_run = out_last;

endmodule

// ===== verif/tb_class_file_header_parser.sv =====
// Testbench for the class file parser: directed and random class files in, parsed words checked one by one.
`timescale 1ns / 1ps

module tb_class_file_header_parser;
  import cfhp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int BYTES_PER_PHASE = 300;
  localparam int LONG_HOLD = 400;
  localparam int UTF_BODY = 255;
  localparam logic [7:0] TAG_UTF8 = 8'd1;

  typedef struct packed {
    logic [7:0] data;
    logic last;
  } byte_item_t;

  typedef struct packed {
    rec_t rec;
    logic last;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  cfhp_byte_if stream_ch ();
  cfhp_rec_if result_ch ();

  class_file_header_parser dut (
    .clk(clk),
    .rst(rst),
    .stream(stream_ch),
    .results(result_ch)
  );

  always #5 clk = ~clk;

  byte_item_t file_bytes[$];
  result_t expected_words[$];
  rec_t step_words[$];
  logic [7:0] build[$];
  int tag_at[$];

  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;
  int words_seen = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  phase_t pstate;
  logic [2:0] fcount;
  logic [31:0] fshift;
  logic [OUT_OFFSET_W-1:0] cur_offset;
  logic [16:0] cur_slot;
  logic [15:0] pool_total;
  logic [15:0] body_left;
  logic [7:0] cur_tag;
  logic [15:0] if_pos;
  logic [15:0] if_total;
  logic [15:0] hdr_words[5];

  function automatic int tag_body(input logic [7:0] t);
    case (t)
      8'd1: return UTF_BODY;
      8'd7, 8'd8, 8'd16, 8'd19, 8'd20: return 2;
      8'd15: return 3;
      8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd17, 8'd18: return 4;
      8'd5, 8'd6: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic bit is_wide(input logic [7:0] t);
    return t == TAG_LONG || t == TAG_DOUBLE;
  endfunction

  function automatic rec_t fresh_word(input logic [2:0] kind);
    rec_t w;
    w = '0;
    w.kind = kind;
    return w;
  endfunction

  function automatic void parser_clear();
    pstate = PH_MAGIC;
    fcount = '0;
    fshift = '0;
    cur_offset = '0;
    cur_slot = 17'd1;
    pool_total = '0;
    body_left = '0;
    cur_tag = '0;
    if_pos = '0;
    if_total = '0;
    foreach (hdr_words[i]) hdr_words[i] = '0;
  endfunction

  function automatic void raise_error(input logic [1:0] code,
                                      input logic [OUT_OFFSET_W-1:0] where,
                                      input logic [7:0] t);
    rec_t w;
    w = fresh_word(KIND_ERROR);
    w.offset = where;
    w.tag = t;
    w.err = code;
    step_words.insert(step_words.size(), w);
    pstate = PH_ERROR;
  endfunction

  function automatic void advance_slot();
    cur_slot = cur_slot + (is_wide(cur_tag) ? 17'd2 : 17'd1);
    pstate = (cur_slot >= {1'b0, pool_total}) ? PH_ACCESS : PH_TAG;
  endfunction

  // Works out the words that one accepted byte causes and queues them.
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    logic [OUT_OFFSET_W-1:0] here;
    int len;
    int need;
    logic [31:0] v;
    rec_t w;
    here = cur_offset;
    cur_offset = cur_offset + OUT_OFFSET_W'(1);
    step_words.delete();
    case (pstate)
      PH_TAG: begin
        len = tag_body(b);
        if (len == 0) begin
          raise_error(ERR_BAD_TAG, here, b);
        end else begin
          w = fresh_word(KIND_POOL);
          w.slot = cur_slot[15:0];
          w.offset = here;
          w.tag = b;
          step_words.insert(step_words.size(), w);
          cur_tag = b;
          if (len == UTF_BODY) begin
            pstate = PH_UTFLEN;
            fcount = '0;
            fshift = '0;
          end else begin
            body_left = 16'(len);
            pstate = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (is_wide(cur_tag) && body_left == WIDE_BODY) begin
          w = fresh_word(KIND_POOL);
          w.slot = cur_slot[15:0] + 16'd1;
          step_words.insert(step_words.size(), w);
        end
        body_left = body_left - 16'd1;
        if (body_left == '0) advance_slot();
      end
      PH_DONE, PH_ERROR: ;
      default: begin
        need = (pstate == PH_MAGIC) ? 4 : 2;
        fshift = {fshift[23:0], b};
        fcount = fcount + 3'd1;
        if (int'(fcount) >= need) begin
          v = fshift;
          fcount = '0;
          fshift = '0;
          case (pstate)
            PH_MAGIC: begin
              if (v != CLASS_MAGIC) raise_error(ERR_BAD_MAGIC, '0, '0);
              else pstate = PH_MINOR;
            end
            PH_MINOR: begin
              hdr_words[0] = v[15:0];
              pstate = PH_MAJOR;
            end
            PH_MAJOR: begin
              hdr_words[1] = v[15:0];
              pstate = PH_POOLCNT;
            end
            PH_POOLCNT: begin
              pool_total = v[15:0];
              cur_slot = 17'd1;
              pstate = (cur_slot >= {1'b0, pool_total}) ? PH_ACCESS : PH_TAG;
            end
            PH_UTFLEN: begin
              body_left = v[15:0];
              if (v == 0) advance_slot();
              else pstate = PH_SKIP;
            end
            PH_ACCESS: begin
              hdr_words[2] = v[15:0];
              pstate = PH_THIS;
            end
            PH_THIS: begin
              hdr_words[3] = v[15:0];
              pstate = PH_SUPER;
            end
            PH_SUPER: begin
              hdr_words[4] = v[15:0];
              w = fresh_word(KIND_HEADER);
              w.minor = hdr_words[0];
              w.major = hdr_words[1];
              w.access = hdr_words[2];
              w.this_idx = hdr_words[3];
              w.super_idx = hdr_words[4];
              step_words.insert(step_words.size(), w);
              pstate = PH_IFCNT;
            end
            PH_IFCNT: begin
              if_total = v[15:0];
              if_pos = '0;
              if (v == 0) begin
                step_words.insert(step_words.size(), fresh_word(KIND_FINISHED));
                pstate = PH_DONE;
              end else begin
                pstate = PH_IFACE;
              end
            end
            default: begin
              w = fresh_word(KIND_IFACE);
              w.slot = if_pos;
              w.iface = v[15:0];
              step_words.insert(step_words.size(), w);
              if_pos = if_pos + 16'd1;
              if (if_pos >= if_total) begin
                step_words.insert(step_words.size(), fresh_word(KIND_FINISHED));
                pstate = PH_DONE;
              end
            end
          endcase
        end
      end
    endcase
    if (last) begin
      if (pstate != PH_DONE && pstate != PH_ERROR) raise_error(ERR_TRUNCATED, cur_offset, '0);
      parser_clear();
    end
    foreach (step_words[i])
      expected_words.insert(expected_words.size(),
                            '{rec: step_words[i], last: i == step_words.size() - 1});
  endfunction

  function automatic void put16(input logic [15:0] v);
    build.insert(build.size(), v[15:8]);
    build.insert(build.size(), v[7:0]);
  endfunction

  function automatic logic [7:0] pick_tag();
    logic [7:0] t;
    do t = 8'($urandom_range(1, 20)); while (tag_body(t) == 0);
    return t;
  endfunction

  function automatic logic [7:0] pick_bad_tag();
    logic [7:0] t;
    do t = 8'($urandom_range(1) ? $urandom_range(21) : $urandom); while (tag_body(t) != 0);
    return t;
  endfunction

  function automatic int queue_build();
    foreach (build[i])
      file_bytes.insert(file_bytes.size(), '{data: build[i], last: i == build.size() - 1});
    return build.size();
  endfunction

  // Builds one class file, mostly well formed, sometimes damaged or cut short.
  function automatic void make_file();
    int flaw;
    int n_pool;
    int s;
    int n_if;
    int len;
    int cut;
    logic [7:0] t;
    build.delete();
    tag_at.delete();
    flaw = $urandom_range(99);
    put16(CLASS_MAGIC[31:16]);
    put16(CLASS_MAGIC[15:0]);
    put16(16'($urandom));
    put16(16'($urandom));
    n_pool = ($urandom_range(7) == 0) ? $urandom_range(1) : $urandom_range(2, 9);
    put16(16'(n_pool));
    s = 1;
    while (s < n_pool) begin
      t = pick_tag();
      tag_at.insert(tag_at.size(), build.size());
      build.insert(build.size(), t);
      if (t == TAG_UTF8) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(3);
        put16(16'(len));
      end else begin
        len = tag_body(t);
      end
      repeat (len) build.insert(build.size(), 8'($urandom));
      s += is_wide(t) ? 2 : 1;
    end
    put16(16'($urandom));
    put16(16'($urandom));
    put16(16'($urandom_range(1) ? $urandom : 32'd0));
    n_if = $urandom_range(3);
    put16(16'(n_if));
    repeat (n_if) put16(16'($urandom));
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) build.insert(build.size(), 8'($urandom));
    if (flaw >= 93) begin
      s = $urandom_range(3);
      build[s] = build[s] ^ (8'd1 << $urandom_range(7));
    end else if (flaw >= 85 && tag_at.size() != 0) begin
      build[tag_at[$urandom_range(tag_at.size() - 1)]] = pick_bad_tag();
    end else if (flaw >= 70) begin
      cut = $urandom_range(1, build.size() - 1);
      while (build.size() > cut) void'(build.pop_back());
    end
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("word %0d: %s got 0x%0h, expected 0x%0h", words_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  task automatic check_word();
    result_t want;
    if (expected_words.size() == 0) begin
      report("unexpected word of kind", 32'(result_ch.record_kind), '0);
    end else begin
      want = expected_words.pop_front();
      check_field("record_kind", 32'(result_ch.record_kind), 32'(want.rec.kind));
      check_field("slot_index", 32'(result_ch.slot_index), 32'(want.rec.slot));
      check_field("entry_offset", 32'(result_ch.entry_offset), 32'(want.rec.offset));
      check_field("entry_tag", 32'(result_ch.entry_tag), 32'(want.rec.tag));
      check_field("minor_version", 32'(result_ch.minor_version), 32'(want.rec.minor));
      check_field("major_version", 32'(result_ch.major_version), 32'(want.rec.major));
      check_field("access_flags", 32'(result_ch.access_flags), 32'(want.rec.access));
      check_field("this_class_index", 32'(result_ch.this_class_index),
                  32'(want.rec.this_idx));
      check_field("super_class_index", 32'(result_ch.super_class_index),
                  32'(want.rec.super_idx));
      check_field("interface_index", 32'(result_ch.interface_index), 32'(want.rec.iface));
      check_field("error_code", 32'(result_ch.error_code), 32'(want.rec.err));
      check_field("last_of_run", 32'(result_ch.last_of_run), 32'(want.last));
    end
    words_seen++;
  endtask

  always @(posedge clk) begin : drive_bytes
    byte_item_t nxt;
    if (rst) begin
      stream_ch.valid <= 1'b0;
      stream_ch.data_byte <= '0;
      stream_ch.last_byte <= 1'b0;
    end else begin
      if (stream_ch.valid && stream_ch.ready)
        parse_byte(stream_ch.data_byte, stream_ch.last_byte);
      if (!stream_ch.valid || stream_ch.ready) begin
        if (file_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = file_bytes.pop_front();
          stream_ch.valid <= 1'b1;
          stream_ch.data_byte <= nxt.data;
          stream_ch.last_byte <= nxt.last;
        end else begin
          stream_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) check_word();
      result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL class_file_header_parser");
      $finish;
    end
  end

  task automatic wait_idle();
    while (file_bytes.size() != 0 || stream_ch.valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int sent;
    rst = 1'b1;
    stream_ch.valid = 1'b0;
    stream_ch.data_byte = '0;
    stream_ch.last_byte = 1'b0;
    result_ch.ready = 1'b0;
    parser_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 21;
    recv_idle = 48;
    // A file cut off inside the magic word.
    build = '{8'hCA};
    void'(queue_build());
    // A bad magic word; the byte after it is ignored.
    build = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    void'(queue_build());
    // Empty pool, no interfaces, one trailing byte after the finished word.
    build = '{8'hCA, 8'hFE, 8'hBA, 8'hBE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
              8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    void'(queue_build());

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 21 : (ph == 1) ? 48 : 0;
      recv_idle = (ph == 0) ? 48 : (ph == 1) ? 21 : 0;
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        make_file();
        sent += queue_build();
      end
      if (ph == 0) hold_req = 1'b1;
      wait_idle();
    end

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("PASS class_file_header_parser");
    end else begin
      $display("FAIL class_file_header_parser");
    end
    $finish;
  end

endmodule
